// File: src/z80il_pkg.sv
package z80il_pkg;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_OPC     = 3'd1;
    localparam logic [2:0] PH_CB_DISP = 3'd2;
    localparam logic [2:0] PH_CB_OP   = 3'd3;
    localparam logic [2:0] PH_ED_OP   = 3'd4;
    localparam logic [2:0] PH_OPER    = 3'd5;

    localparam logic [1:0] TK_NONE = 2'd0;
    localparam logic [1:0] TK_REL  = 2'd1;
    localparam logic [1:0] TK_ABS  = 2'd2;

    localparam logic [1:0] IDX_NONE = 2'd0;
    localparam logic [1:0] IDX_IX   = 2'd1;
    localparam logic [1:0] IDX_IY   = 2'd2;

    localparam logic [1:0] GRP_MAIN = 2'd0;
    localparam logic [1:0] GRP_CB   = 2'd1;
    localparam logic [1:0] GRP_ED   = 2'd2;

    localparam logic [7:0] OP_PFX_IX = 8'hdd;
    localparam logic [7:0] OP_PFX_IY = 8'hfd;
    localparam logic [7:0] OP_PFX_CB = 8'hcb;
    localparam logic [7:0] OP_PFX_ED = 8'hed;

    localparam logic [7:0] LEN_MAX = 8'hff;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] next_addr;
        logic [7:0]  byte_count;
        logic        capped;
        logic [1:0]  index_sel;
        logic [1:0]  group_sel;
        logic [7:0]  opcode;
        logic [7:0]  operand_low;
        logic [1:0]  bytes_rem;
        logic [1:0]  target_kind;
    } t_state;

    typedef struct packed {
        logic [7:0]  length;
        logic        length_capped;
        logic        has_target;
        logic [15:0] target;
        logic [1:0]  table_group;
        logic [1:0]  index_reg;
        logic [7:0]  opcode;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        logic [1:0] kind;
    } t_oper;

    // operand bytes and target kind following a main-table opcode
    function automatic t_oper main_operands(input logic [7:0] op, input logic ix);
        logic [1:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic       q;
        logic       y6;
        t_oper      r;
        x  = op[7:6];
        y  = op[5:3];
        z  = op[2:0];
        q  = op[3];
        y6 = (y == 3'd6);
        r.count = 2'd0;
        r.kind  = TK_NONE;
        unique case (x)
            2'd0: begin
                unique case (z)
                    3'd0: if (y >= 3'd2) begin
                        r.count = 2'd1;
                        r.kind  = TK_REL;
                    end
                    3'd1: if (!q) r.count = 2'd2;
                    3'd2: if (y[2]) begin
                        r.count = 2'd2;
                        r.kind  = TK_ABS;
                    end
                    3'd4, 3'd5: if (ix && y6) r.count = 2'd1;
                    3'd6: r.count = (ix && y6) ? 2'd2 : 2'd1;
                    default: ;
                endcase
            end
            2'd1: begin
                if (ix && !(y6 && z == 3'd6) && (y6 || z == 3'd6)) r.count = 2'd1;
            end
            2'd2: begin
                if (ix && z == 3'd6) r.count = 2'd1;
            end
            default: begin
                unique case (z)
                    3'd2, 3'd4: begin
                        r.count = 2'd2;
                        r.kind  = TK_ABS;
                    end
                    3'd3: begin
                        if (y == 3'd0) begin
                            r.count = 2'd2;
                            r.kind  = TK_ABS;
                        end else if (y == 3'd2 || y == 3'd3) begin
                            r.count = 2'd1;
                        end
                    end
                    3'd5: if (q) begin
                        r.count = 2'd2;
                        r.kind  = TK_ABS;
                    end
                    3'd6: r.count = 2'd1;
                    default: ;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// File: src/z80il_step.sv
module z80il_step
    import z80il_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_code_byte,
    input  logic        i_start_req,
    input  logic [15:0] i_start_addr,
    output t_state      o_state,
    output logic        o_emit,
    output t_result     o_result
);

    t_state      s;
    t_oper       oper;
    logic        emit;
    logic        has_t;
    logic [15:0] tgt;
    logic [15:0] disp;

    always_comb begin
        s     = i_state;
        emit  = 1'b0;
        has_t = 1'b0;
        tgt   = 16'h0000;
        oper  = main_operands(i_code_byte, i_state.index_sel != IDX_NONE);
        disp  = {{8{i_code_byte[7]}}, i_code_byte};

        if (i_start_req || s.phase < PH_OPC || s.phase > PH_OPER) begin
            if (i_start_req) s.next_addr = i_start_addr;
            s.byte_count  = 8'd0;
            s.capped      = 1'b0;
            s.index_sel   = IDX_NONE;
            s.group_sel   = GRP_MAIN;
            s.opcode      = 8'd0;
            s.operand_low = 8'd0;
            s.bytes_rem   = 2'd0;
            s.target_kind = TK_NONE;
            s.phase       = PH_OPC;
            // index prefix was cleared: operands follow the unprefixed table
            oper = main_operands(i_code_byte, 1'b0);
        end

        if (s.byte_count == LEN_MAX) s.capped = 1'b1;
        else s.byte_count = s.byte_count + 8'd1;
        s.next_addr = s.next_addr + 16'd1;

        unique case (s.phase)
            PH_OPC: begin
                if (i_code_byte == OP_PFX_IX) begin
                    s.index_sel = IDX_IX;
                end else if (i_code_byte == OP_PFX_IY) begin
                    s.index_sel = IDX_IY;
                end else if (i_code_byte == OP_PFX_CB) begin
                    s.group_sel = GRP_CB;
                    s.phase = (s.index_sel != IDX_NONE) ? PH_CB_DISP : PH_CB_OP;
                end else if (i_code_byte == OP_PFX_ED) begin
                    s.group_sel = GRP_ED;
                    s.phase     = PH_ED_OP;
                end else begin
                    s.opcode = i_code_byte;
                    if (oper.count == 2'd0) begin
                        emit = 1'b1;
                        // RST y*8
                        if ((i_code_byte & 8'hc7) == 8'hc7) begin
                            has_t = 1'b1;
                            tgt   = {10'd0, i_code_byte[5:3], 3'b000};
                        end
                    end else begin
                        s.bytes_rem   = oper.count;
                        s.target_kind = oper.kind;
                        s.phase       = PH_OPER;
                    end
                end
            end
            PH_CB_DISP: s.phase = PH_CB_OP;
            PH_CB_OP: begin
                s.opcode = i_code_byte;
                emit     = 1'b1;
            end
            PH_ED_OP: begin
                s.opcode = i_code_byte;
                // ED LD (nn),rp / LD rp,(nn)
                if ((i_code_byte & 8'hc7) == 8'h43) begin
                    s.bytes_rem   = 2'd2;
                    s.target_kind = TK_ABS;
                    s.phase       = PH_OPER;
                end else begin
                    emit = 1'b1;
                end
            end
            default: begin
                if (s.bytes_rem == 2'd2) s.operand_low = i_code_byte;
                if (s.bytes_rem != 2'd0) s.bytes_rem = s.bytes_rem - 2'd1;
                if (s.bytes_rem == 2'd0) begin
                    emit = 1'b1;
                    if (s.target_kind == TK_REL) begin
                        has_t = 1'b1;
                        tgt   = s.next_addr + disp;
                    end else if (s.target_kind == TK_ABS) begin
                        has_t = 1'b1;
                        tgt   = {i_code_byte, s.operand_low};
                    end
                end
            end
        endcase

        if (emit) s.phase = PH_IDLE;
    end

    assign o_state = s;
    assign o_emit  = emit;

    always_comb begin
        o_result.length        = s.byte_count;
        o_result.length_capped = s.capped;
        o_result.has_target    = has_t;
        o_result.target        = tgt;
        o_result.table_group   = s.group_sel;
        o_result.index_reg     = s.index_sel;
        o_result.opcode        = s.opcode;
    end

endmodule

// File: src/z80_instruction_length_predecoder.sv
// Channel  Handshake                     Payload
// -------  ----------------------------  -------------------------------------
// in       i_in_valid / o_in_ready       i_code_byte, i_start_req, i_start_addr
// out      o_out_valid / i_out_ready     o_length, o_length_capped, o_has_target,
//                                        o_target, o_table_group, o_index_reg,
//                                        o_opcode
//
// One code byte per cycle unless a full output register stalls input; the decode
// state register holds the partial instruction. The result of the closing byte is
// in the output register on the next cycle. A byte is taken whenever the output
// register is empty or drains in the same cycle. Synchronous reset returns the
// decoder to idle with address zero and drops any pending result.
module z80_instruction_length_predecoder
    import z80il_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    input  logic        i_start_req,
    input  logic [15:0] i_start_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_length,
    output logic        o_length_capped,
    output logic        o_has_target,
    output logic [15:0] o_target,
    output logic [1:0]  o_table_group,
    output logic [1:0]  o_index_reg,
    output logic [7:0]  o_opcode
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    step_emit;
    logic    in_xfer;

    z80il_step u_step (
        .i_state      (r_state),
        .i_code_byte  (i_code_byte),
        .i_start_req  (i_start_req),
        .i_start_addr (i_start_addr),
        .o_state      (n_state),
        .o_emit       (step_emit),
        .o_result     (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) r_state <= n_state;
            if (in_xfer) r_out_valid <= step_emit;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && step_emit) r_result <= n_result;
    end

    assign o_out_valid     = r_out_valid;
    assign o_length        = r_result.length;
    assign o_length_capped = r_result.length_capped;
    assign o_has_target    = r_result.has_target;
    assign o_target        = r_result.target;
    assign o_table_group   = r_result.table_group;
    assign o_index_reg     = r_result.index_reg;
    assign o_opcode        = r_result.opcode;

    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_target) |-> (o_target == 16'h0000))
        else $error("target nonzero without has_target");

    a_capped_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_capped) |-> (o_length == LEN_MAX))
        else $error("capped length below maximum");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length != 8'd0))
        else $error("zero length result");

    a_idle_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && step_emit) |=> (r_state.phase == PH_IDLE))
        else $error("decoder not idle after result");

endmodule
